[design/aptf_pkg.sv]
// Shared types, register indexes and the rotation table of the 2D affine point transform.
// No dependencies; used by aptf_cfg, the top level and the testbench.
package aptf_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int COEF_W          = 16;
    localparam int ADDR_W          = 3;
    localparam int ANGLE_W         = 9;
    localparam int MODE_W          = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_TRANSLATE = 3'd0,
        MODE_SCALE     = 3'd1,
        MODE_ROTATE    = 3'd2,
        MODE_REFLECT   = 3'd3,
        MODE_SHEAR     = 3'd4
    } t_mode;

    localparam logic [ADDR_W-1:0] REG_MODE     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COEF_A   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COEF_B   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_ANCHOR_X = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ANCHOR_Y = 3'd4;
    localparam logic [ADDR_W-1:0] REG_ANGLE    = 3'd5;

    localparam logic signed [COEF_W-1:0] Q8_ONE     = 16'sd256;
    localparam logic signed [COEF_W-1:0] Q8_NEG_ONE = -16'sd256;
    localparam logic signed [COEF_W-1:0] Q14_ONE    = 16'sd16384;

    typedef struct packed {
        logic signed [COEF_W-1:0] sin_v;
        logic signed [COEF_W-1:0] cos_v;
    } t_trig;

    // Configuration seen by the datapath (anchors travel separately, their width is a parameter)
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] sin_v;
        logic signed [COEF_W-1:0] cos_v;
    } t_cfg;

    // round(16384 * sin(d deg)), d = 0..90
    localparam logic [14:0] QUARTER_SINE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    // Sine and cosine in Q1.14 for a whole-degree angle; angles past 359 wrap once
    function automatic t_trig trig_of(input logic [ANGLE_W-1:0] deg);
        logic [ANGLE_W-1:0] ang;
        logic [ANGLE_W-1:0] diff;
        logic [1:0]         quad;
        logic [6:0]         rem;
        logic signed [COEF_W-1:0] lo;
        logic signed [COEF_W-1:0] hi;
        t_trig              res;
        ang = (deg >= 9'd360) ? deg - 9'd360 : deg;
        priority if (ang >= 9'd270) begin
            quad = 2'd3;
            diff = ang - 9'd270;
        end else if (ang >= 9'd180) begin
            quad = 2'd2;
            diff = ang - 9'd180;
        end else if (ang >= 9'd90) begin
            quad = 2'd1;
            diff = ang - 9'd90;
        end else begin
            quad = 2'd0;
            diff = ang;
        end
        rem = diff[6:0];
        lo  = signed'({1'b0, QUARTER_SINE[rem]});
        hi  = signed'({1'b0, QUARTER_SINE[7'd90 - rem]});
        unique case (quad)
            2'd0: begin res.sin_v = lo;  res.cos_v = hi;  end
            2'd1: begin res.sin_v = hi;  res.cos_v = -lo; end
            2'd2: begin res.sin_v = -lo; res.cos_v = -hi; end
            2'd3: begin res.sin_v = -hi; res.cos_v = lo;  end
        endcase
        return res;
    endfunction

endpackage

[design/aptf_cfg.sv]
// Configuration register file of the 2D affine point transform.
// Depends on aptf_pkg; turns the angle into sine/cosine at write time.
module aptf_cfg #(
    parameter int COORD_WIDTH = aptf_pkg::COORD_WIDTH_DEF,
    parameter int CFG_DW      = (COORD_WIDTH > aptf_pkg::COEF_W) ? COORD_WIDTH
                                                                 : aptf_pkg::COEF_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [aptf_pkg::ADDR_W-1:0]   i_wr_addr,
    input  logic [CFG_DW-1:0]             i_wr_data,
    output aptf_pkg::t_cfg                o_cfg,
    output logic signed [COORD_WIDTH-1:0] o_anchor_x,
    output logic signed [COORD_WIDTH-1:0] o_anchor_y
);
    import aptf_pkg::*;

    t_cfg                          r_cfg;
    logic signed [COORD_WIDTH-1:0] r_anchor_x;
    logic signed [COORD_WIDTH-1:0] r_anchor_y;
    t_trig                         n_trig;

    assign n_trig = trig_of(i_wr_data[ANGLE_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_TRANSLATE;
            r_cfg.coef_a <= Q8_ONE;
            r_cfg.coef_b <= Q8_ONE;
            r_cfg.sin_v  <= '0;
            r_cfg.cos_v  <= Q14_ONE;
            r_anchor_x   <= '0;
            r_anchor_y   <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_addr)
                REG_MODE:     r_cfg.mode   <= i_wr_data[MODE_W-1:0];
                REG_COEF_A:   r_cfg.coef_a <= signed'(i_wr_data[COEF_W-1:0]);
                REG_COEF_B:   r_cfg.coef_b <= signed'(i_wr_data[COEF_W-1:0]);
                REG_ANCHOR_X: r_anchor_x   <= signed'(i_wr_data[COORD_WIDTH-1:0]);
                REG_ANCHOR_Y: r_anchor_y   <= signed'(i_wr_data[COORD_WIDTH-1:0]);
                REG_ANGLE: begin
                    r_cfg.sin_v <= n_trig.sin_v;
                    r_cfg.cos_v <= n_trig.cos_v;
                end
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg      = r_cfg;
    assign o_anchor_x = r_anchor_x;
    assign o_anchor_y = r_anchor_y;

endmodule

[design/aptf_round_sat.sv]
// One axis of the output stage: round the product sum, add the base, saturate.
// Depends on nothing beyond its ports; combinational.
module aptf_round_sat #(
    parameter int COORD_WIDTH = 20
) (
    input  logic signed [COORD_WIDTH+17:0] i_sum,
    input  logic                           i_sh14,
    input  logic signed [COORD_WIDTH-1:0]  i_base,
    output logic signed [COORD_WIDTH-1:0]  o_val,
    output logic                           o_clip
);
    localparam int SW = COORD_WIDTH + 18;
    localparam int VW = COORD_WIDTH + 19;
    localparam logic signed [VW-1:0] MAX_V = signed'({{(VW-COORD_WIDTH+1){1'b0}},
                                                      {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [VW-1:0] MIN_V = ~MAX_V;

    logic signed [SW-1:0] half;
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] rnd;
    logic signed [VW-1:0] v;

    always_comb begin
        half = i_sh14 ? SW'(15'sh2000) : SW'(9'sh080);
        t    = i_sum + half;
        rnd  = i_sh14 ? (t >>> 14) : (t >>> 8);
        v    = signed'({rnd[SW-1], rnd}) + signed'({{(VW-COORD_WIDTH){i_base[COORD_WIDTH-1]}},
                                                    i_base});
        priority if (v > MAX_V) begin
            o_val  = MAX_V[COORD_WIDTH-1:0];
            o_clip = 1'b1;
        end else if (v < MIN_V) begin
            o_val  = MIN_V[COORD_WIDTH-1:0];
            o_clip = 1'b1;
        end else begin
            o_val  = v[COORD_WIDTH-1:0];
            o_clip = 1'b0;
        end
    end

endmodule

[design/affine_point_transform_2d_core.sv]
// Top level of the 2D affine point transform: config registers, multiply stage, output stage.
// Depends on aptf_pkg, aptf_cfg and aptf_round_sat.
//
// Usage
//   Input channel : i_in_valid / o_in_stall, payload i_x_in, i_y_in (signed, 8 fraction bits).
//   Output channel: o_out_valid / i_out_stall, payload o_x_out, o_y_out, o_saturated.
//   A transaction completes on a rising edge with valid high and stall low.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_addr, i_cfg_data.
//   Registers: mode, coef_a, coef_b, anchor_x, anchor_y, angle_deg at indexes 0..5;
//   other indexes are dropped. Write config only while no vertex is in flight.
// Timing
//   Three register stages: input capture, multiply, round/saturate. An accepted vertex
//   passes through them in that order to the output. Throughput is one vertex per
//   clock: every stage takes a new vertex each cycle while the output is not stalled.
// Stall
//   Each stage moves on when it is empty or the stage after it moves, so bubbles close
//   up under output stall; o_in_stall rises only once all three stages hold data and
//   the output is stalled. A stalled output holds its payload.
// Reset
//   Synchronous, active low: pipeline empties, registers take their defaults
//   (translate, unity coefficients, zero anchors, zero angle).
module affine_point_transform_2d_core #(
    parameter int COORD_WIDTH = aptf_pkg::COORD_WIDTH_DEF,
    localparam int CFG_DW     = (COORD_WIDTH > aptf_pkg::COEF_W) ? COORD_WIDTH
                                                                 : aptf_pkg::COEF_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // vertex in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_x_in,
    input  logic signed [COORD_WIDTH-1:0] i_y_in,
    // vertex out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_x_out,
    output logic signed [COORD_WIDTH-1:0] o_y_out,
    output logic                          o_saturated,
    // config writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aptf_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]             i_cfg_data
);
    import aptf_pkg::*;

    localparam int OW = COORD_WIDTH + 1;   // operand width, holds a difference
    localparam int PW = COORD_WIDTH + 17;  // product width
    localparam int SW = COORD_WIDTH + 18;  // sum of two products

    t_cfg                          cfg;
    logic signed [COORD_WIDTH-1:0] anchor_x;
    logic signed [COORD_WIDTH-1:0] anchor_y;

    aptf_cfg #(
        .COORD_WIDTH (COORD_WIDTH),
        .CFG_DW      (CFG_DW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_addr  (i_cfg_addr),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg),
        .o_anchor_x (anchor_x),
        .o_anchor_y (anchor_y)
    );

    assign o_cfg_ready = 1'b1;

    // ---------------- pipeline control ----------------
    logic r_s1_vld, r_s2_vld, r_out_vld;
    logic adv1, adv2, adv3;

    assign adv3       = !r_out_vld || !i_out_stall;
    assign adv2       = !r_s2_vld || adv3;
    assign adv1       = !r_s1_vld || adv2;
    assign o_in_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv1) r_s1_vld  <= i_in_valid;
            if (adv2) r_s2_vld  <= r_s1_vld;
            if (adv3) r_out_vld <= r_s2_vld;
        end
    end

    // ---------------- stage 1: input capture ----------------
    logic signed [COORD_WIDTH-1:0] r_s1_x, r_s1_y;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && adv1) begin
            r_s1_x <= i_x_in;
            r_s1_y <= i_y_in;
        end
    end

    // ---------------- stage 2: operand select and multiply ----------------
    // Every mode is written as base + round(op0*k0 + op1*k1); translate and
    // reflect use the products by +/-1.0 in Q8.8 so the whole path stays shared.
    logic signed [OW-1:0]     xe, ye, hxe, hye, dx, dy;
    logic signed [OW-1:0]     ox0, ox1, oy0, oy1;
    logic signed [COEF_W-1:0] kx0, kx1, ky0, ky1;
    logic signed [COORD_WIDTH-1:0] n_bx, n_by;
    logic                     n_sh14;
    logic signed [PW-1:0]     n_px0, n_px1, n_py0, n_py1;

    always_comb begin
        xe  = signed'({r_s1_x[COORD_WIDTH-1], r_s1_x});
        ye  = signed'({r_s1_y[COORD_WIDTH-1], r_s1_y});
        hxe = signed'({anchor_x[COORD_WIDTH-1], anchor_x});
        hye = signed'({anchor_y[COORD_WIDTH-1], anchor_y});
        dx  = xe - hxe;
        dy  = ye - hye;

        // unused mode codes pass the vertex through
        ox0 = xe;  kx0 = Q8_ONE;  ox1 = '0;  kx1 = '0;
        oy0 = ye;  ky0 = Q8_ONE;  oy1 = '0;  ky1 = '0;
        n_bx = '0; n_by = '0; n_sh14 = 1'b0;

        unique case (cfg.mode)
            MODE_TRANSLATE: begin
                ox1 = hxe; kx1 = Q8_ONE;
                oy1 = hye; ky1 = Q8_ONE;
            end
            MODE_SCALE: begin
                ox0 = dx; kx0 = cfg.coef_a;
                oy0 = dy; ky0 = cfg.coef_b;
                n_bx = anchor_x; n_by = anchor_y;
            end
            MODE_ROTATE: begin
                ox0 = dx; kx0 = cfg.cos_v;  ox1 = dy; kx1 = -cfg.sin_v;
                oy0 = dx; ky0 = cfg.sin_v;  oy1 = dy; ky1 = cfg.cos_v;
                n_bx = anchor_x; n_by = anchor_y;
                n_sh14 = 1'b1;
            end
            MODE_REFLECT: begin
                kx0 = Q8_NEG_ONE;
            end
            MODE_SHEAR: begin
                ox0 = ye; kx0 = cfg.coef_a;
                oy0 = xe; ky0 = cfg.coef_b;
                n_bx = r_s1_x; n_by = r_s1_y;
            end
            default: ;
        endcase

        n_px0 = PW'(ox0) * PW'(kx0);
        n_px1 = PW'(ox1) * PW'(kx1);
        n_py0 = PW'(oy0) * PW'(ky0);
        n_py1 = PW'(oy1) * PW'(ky1);
    end

    logic signed [PW-1:0]          r_px0, r_px1, r_py0, r_py1;
    logic signed [COORD_WIDTH-1:0] r_bx, r_by;
    logic                          r_sh14;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && adv2) begin
            r_px0  <= n_px0;
            r_px1  <= n_px1;
            r_py0  <= n_py0;
            r_py1  <= n_py1;
            r_bx   <= n_bx;
            r_by   <= n_by;
            r_sh14 <= n_sh14;
        end
    end

    // ---------------- stage 3: round, add base, saturate ----------------
    logic signed [SW-1:0]          sum_x, sum_y;
    logic signed [COORD_WIDTH-1:0] n_x_out, n_y_out;
    logic                          clip_x, clip_y;

    assign sum_x = signed'({r_px0[PW-1], r_px0}) + signed'({r_px1[PW-1], r_px1});
    assign sum_y = signed'({r_py0[PW-1], r_py0}) + signed'({r_py1[PW-1], r_py1});

    aptf_round_sat #(.COORD_WIDTH(COORD_WIDTH)) u_rs_x (
        .i_sum  (sum_x),
        .i_sh14 (r_sh14),
        .i_base (r_bx),
        .o_val  (n_x_out),
        .o_clip (clip_x)
    );

    aptf_round_sat #(.COORD_WIDTH(COORD_WIDTH)) u_rs_y (
        .i_sum  (sum_y),
        .i_sh14 (r_sh14),
        .i_base (r_by),
        .o_val  (n_y_out),
        .o_clip (clip_y)
    );

    logic signed [COORD_WIDTH-1:0] r_x_out, r_y_out;
    logic                          r_sat;

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && adv3) begin
            r_x_out <= n_x_out;
            r_y_out <= n_y_out;
            r_sat   <= clip_x | clip_y;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_x_out     = r_x_out;
    assign o_y_out     = r_y_out;
    assign o_saturated = r_sat;

endmodule

[design/aptf_checker.sv]
// Port-level assertions for the 2D affine point transform, bound to the top level.
// Depends on affine_point_transform_2d_core's port list.
module aptf_checker #(
    parameter int COORD_WIDTH = 20
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [COORD_WIDTH-1:0] o_x_out,
    input logic signed [COORD_WIDTH-1:0] o_y_out,
    input logic                          o_saturated
);
    localparam logic signed [COORD_WIDTH-1:0] MAX_C = signed'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [COORD_WIDTH-1:0] MIN_C = ~MAX_C;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_x_out)
            && $stable(o_y_out) && $stable(o_saturated))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input backpressure only when the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    // a clipped result sits on a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> (o_x_out == MAX_C) || (o_x_out == MIN_C)
            || (o_y_out == MAX_C) || (o_y_out == MIN_C))
        else $error("saturated flag without clipped coordinate");

endmodule

bind affine_point_transform_2d_core aptf_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_aptf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_x_out     (o_x_out),
    .o_y_out     (o_y_out),
    .o_saturated (o_saturated)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for affine_point_transform_2d_core: directed vertex table, then
// random vertices under changing setups and flow control. Depends on aptf_pkg and the core.
module testbench;
    import aptf_pkg::*;

    localparam int CW           = 20;                  // coordinate width
    localparam int CFG_W        = (CW > COEF_W) ? CW : COEF_W;
    localparam int HOLD_CYCLES  = 48;                  // long output hold-off
    localparam int SETTLE       = 8;                   // pipeline is 3 deep
    localparam int QUIET_LIMIT  = 5000;                // cycles with no transaction at all
    localparam int BLOCKS       = 18;                  // setups per flow-control regime
    localparam int BLOCK_ITEMS  = 25;

    localparam logic signed [CW-1:0] X_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] X_MIN = {1'b1, {(CW-1){1'b0}}};

    // mode codes the core does not define: vertex passes through
    localparam logic [MODE_W-1:0] MODE_PASS_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PASS_HI = 3'd7;
    // register indexes past the map: writes must be dropped
    localparam logic [ADDR_W-1:0] REG_NONE_LO  = 3'd6;
    localparam logic [ADDR_W-1:0] REG_NONE_HI  = 3'd7;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 sat;
    } t_vertex;

    // one directed vertex with the setup it runs under
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [CW-1:0]     hx;
        logic signed [CW-1:0]     hy;
        logic [ANGLE_W-1:0]       ang;
        logic signed [CW-1:0]     x;
        logic signed [CW-1:0]     y;
        logic                     typed;   // expected value given below
        logic signed [CW-1:0]     ex;
        logic signed [CW-1:0]     ey;
        logic                     es;
    } t_vec_row;

    // mode, coef_a, coef_b, anchor x/y, angle | vertex | typed, expected x, y, clip flag
    t_vec_row directed_rows [0:24] = '{
        // default setup after reset: plain translate by zero
        '{MODE_TRANSLATE, Q8_ONE, Q8_ONE, 0, 0, 0, 256, -512, 1, 256, -512, 0},
        '{MODE_TRANSLATE, Q8_ONE, Q8_ONE, 0, 0, 0, X_MAX, X_MIN, 1, X_MAX, X_MIN, 0},
        // offsets that push both coordinates past the range, then a small in-range offset
        '{MODE_TRANSLATE, Q8_ONE, Q8_ONE, X_MAX, X_MIN, 0, X_MAX, X_MIN, 1, X_MAX, X_MIN, 1},
        '{MODE_TRANSLATE, Q8_ONE, Q8_ONE, -1, 1, 0, X_MIN, X_MAX, 1, X_MIN, X_MAX, 1},
        '{MODE_TRANSLATE, Q8_ONE, Q8_ONE, 100, -100, 0, 5, 5, 1, 105, -95, 0},
        // scale: unity, 2x / -1x about a pivot, extreme factors, half-LSB ties
        '{MODE_SCALE, Q8_ONE, Q8_ONE, 0, 0, 0, 1234, -77, 1, 1234, -77, 0},
        '{MODE_SCALE, 512, Q8_NEG_ONE, 100, 200, 0, 300, 400, 1, 500, 0, 0},
        '{MODE_SCALE, 32767, -32768, 0, 0, 0, X_MAX, X_MAX, 0, 0, 0, 0},
        '{MODE_SCALE, 128, 128, 0, 0, 0, 1, -1, 1, 1, 0, 0},
        '{MODE_SCALE, -32768, 32767, X_MIN, X_MAX, 0, X_MAX, X_MIN, 0, 0, 0, 0},
        // rotate: the four quadrant axes, wrap past 359, odd angles, extreme pivots
        '{MODE_ROTATE, Q8_ONE, Q8_ONE, 0, 0, 0, 1000, -500, 1, 1000, -500, 0},
        '{MODE_ROTATE, Q8_ONE, Q8_ONE, 0, 0, 90, 1000, -500, 1, 500, 1000, 0},
        '{MODE_ROTATE, Q8_ONE, Q8_ONE, 0, 0, 180, 1000, -500, 1, -1000, 500, 0},
        '{MODE_ROTATE, Q8_ONE, Q8_ONE, 0, 0, 270, 1000, -500, 1, -500, -1000, 0},
        '{MODE_ROTATE, Q8_ONE, Q8_ONE, X_MAX, X_MIN, 359, X_MIN, X_MAX, 0, 0, 0, 0},
        '{MODE_ROTATE, Q8_ONE, Q8_ONE, 0, 0, 360, 1000, -500, 1, 1000, -500, 0},
        '{MODE_ROTATE, Q8_ONE, Q8_ONE, 0, 0, 511, X_MAX, X_MIN, 0, 0, 0, 0},
        '{MODE_ROTATE, Q8_ONE, Q8_ONE, 256, 256, 45, X_MAX, X_MAX, 0, 0, 0, 0},
        // reflect: negating the most negative x clips
        '{MODE_REFLECT, Q8_ONE, Q8_ONE, 0, 0, 0, X_MIN, 5, 1, X_MAX, 5, 1},
        '{MODE_REFLECT, Q8_ONE, Q8_ONE, 0, 0, 0, X_MAX, X_MIN, 1, -X_MAX, X_MIN, 0},
        '{MODE_REFLECT, Q8_ONE, Q8_ONE, 0, 0, 0, 0, 0, 1, 0, 0, 0},
        // shear
        '{MODE_SHEAR, Q8_ONE, 0, 0, 0, 0, 100, 50, 1, 150, 50, 0},
        '{MODE_SHEAR, -32768, 32767, X_MAX, X_MIN, 0, X_MAX, X_MIN, 0, 0, 0, 0},
        // undefined modes pass through
        '{MODE_PASS_LO, Q8_ONE, Q8_ONE, 0, 0, 0, X_MAX, X_MIN, 1, X_MAX, X_MIN, 0},
        '{MODE_PASS_HI, Q8_ONE, Q8_ONE, 0, 0, 0, -3, 9, 1, -3, 9, 0}
    };

    // ---------------------------------------------------------------- DUT ports
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic signed [CW-1:0] i_x_in      = '0;
    logic signed [CW-1:0] i_y_in      = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [CW-1:0] o_x_out;
    logic signed [CW-1:0] o_y_out;
    logic                 o_saturated;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [ADDR_W-1:0]    i_cfg_addr  = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // ---------------------------------------------------------------- shadow setup
    // Mirrors the core's registers; starts at the reset defaults.
    logic [MODE_W-1:0]        cfg_mode     = MODE_TRANSLATE;
    logic signed [COEF_W-1:0] cfg_coef_a   = Q8_ONE;
    logic signed [COEF_W-1:0] cfg_coef_b   = Q8_ONE;
    logic signed [CW-1:0]     cfg_anchor_x = '0;
    logic signed [CW-1:0]     cfg_anchor_y = '0;
    logic [ANGLE_W-1:0]       cfg_angle    = '0;

    t_vertex pending_vertices [$];   // expected results, oldest first
    t_vertex head_v;
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      send_gap_pct = 0;       // chance per cycle that the source idles
    int      stall_pct    = 0;       // chance per cycle that the sink stalls
    int      hold_asks    = 0;       // bumped to request a long sink hold-off
    int      hold_served  = 0;

    affine_point_transform_2d_core #(.COORD_WIDTH(CW)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    // add half an LSB, then floor: ties go toward +inf
    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // MSB of the result flags a clip
    function automatic logic [CW:0] clamp_coord(input longint v);
        if (v > longint'(X_MAX)) return {1'b1, X_MAX};
        if (v < longint'(X_MIN)) return {1'b1, X_MIN};
        return {1'b0, v[CW-1:0]};
    endfunction

    function automatic t_vertex transform_vertex(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
        longint    vx, vy, ca, cb, px, py, dx, dy, sn, cs, lo, hi, rx, ry;
        int        ang, quad, rem;
        logic [CW:0] cx, cy;
        t_vertex   r;
        vx = longint'(x);
        vy = longint'(y);
        ca = longint'(cfg_coef_a);
        cb = longint'(cfg_coef_b);
        px = longint'(cfg_anchor_x);
        py = longint'(cfg_anchor_y);
        rx = vx;
        ry = vy;
        case (cfg_mode)
            MODE_TRANSLATE: begin
                rx = vx + px;
                ry = vy + py;
            end
            MODE_SCALE: begin
                rx = px + rnd_shift(ca * (vx - px), 8);
                ry = py + rnd_shift(cb * (vy - py), 8);
            end
            MODE_ROTATE: begin
                ang  = int'(cfg_angle) % 360;
                quad = ang / 90;
                rem  = ang % 90;
                lo   = longint'(QUARTER_SINE[rem]);
                hi   = longint'(QUARTER_SINE[90 - rem]);
                case (quad)
                    0: begin sn = lo;  cs = hi;  end
                    1: begin sn = hi;  cs = -lo; end
                    2: begin sn = -lo; cs = -hi; end
                    default: begin sn = -hi; cs = lo; end
                endcase
                dx = vx - px;
                dy = vy - py;
                rx = px + rnd_shift(dx * cs - dy * sn, 14);
                ry = py + rnd_shift(dx * sn + dy * cs, 14);
            end
            MODE_REFLECT: rx = -vx;
            MODE_SHEAR: begin
                rx = vx + rnd_shift(ca * vy, 8);
                ry = vy + rnd_shift(cb * vx, 8);
            end
            default: ;  // undefined modes: unchanged
        endcase
        cx = clamp_coord(rx);
        cy = clamp_coord(ry);
        r.x   = cx[CW-1:0];
        r.y   = cy[CW-1:0];
        r.sat = cx[CW] | cy[CW];
        return r;
    endfunction

    // register write as the core sees it: data is cut to the register width
    function automatic void apply_reg(input logic [ADDR_W-1:0] idx,
                                      input logic [CFG_W-1:0] d);
        case (idx)
            REG_MODE:     cfg_mode     = d[MODE_W-1:0];
            REG_COEF_A:   cfg_coef_a   = d[COEF_W-1:0];
            REG_COEF_B:   cfg_coef_b   = d[COEF_W-1:0];
            REG_ANCHOR_X: cfg_anchor_x = d[CW-1:0];
            REG_ANCHOR_Y: cfg_anchor_y = d[CW-1:0];
            REG_ANGLE:    cfg_angle    = d[ANGLE_W-1:0];
            default: ;    // no such register
        endcase
    endfunction

    // ---------------------------------------------------------------- random picks
    function automatic logic signed [CW-1:0] pick_coord();
        logic [CW-1:0] raw;
        raw = CW'($urandom);
        case ($urandom_range(9))
            0: return X_MIN;
            1: return X_MAX;
            2: return '0;
            3: return '1;
            4, 5, 6: return raw;
            default: return {{(CW-13){raw[12]}}, raw[12:0]};  // near the origin
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        logic [COEF_W-1:0] raw;
        raw = COEF_W'($urandom);
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767;
            2: return Q8_ONE;
            3: return Q8_NEG_ONE;
            4: return '0;
            5: return raw;
            default: return {{(COEF_W-11){raw[10]}}, raw[10:0]};  // within +-4.0
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers
    // All tasks start and end on a rising edge; every drive is nonblocking.
    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Loads a full setup; unused data bits carry junk to check they are dropped.
    task automatic load_setup(input logic [MODE_W-1:0] mode,
                              input logic signed [COEF_W-1:0] a,
                              input logic signed [COEF_W-1:0] b,
                              input logic signed [CW-1:0] hx,
                              input logic signed [CW-1:0] hy,
                              input logic [ANGLE_W-1:0] ang);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        write_reg(REG_MODE,     {junk[CFG_W-1:MODE_W], mode});
        write_reg(REG_COEF_A,   {junk[CFG_W-1:COEF_W], a});
        write_reg(REG_COEF_B,   {junk[COEF_W-1:COEF_W-(CFG_W-COEF_W)], b});
        write_reg(REG_ANCHOR_X, hx);
        write_reg(REG_ANCHOR_Y, hy);
        write_reg(REG_ANGLE,    {junk[CFG_W-1:ANGLE_W], ang});
    endtask

    // Offers one vertex, possibly after idle cycles, and books its expected result
    // at the edge the transaction completes. Valid stays up for a back-to-back item.
    task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic typed, input t_vertex want);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_x_in     <= x;
        i_y_in     <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_vertices.push_back(typed ? want : transform_vertex(x, y));
    endtask

    // Source goes quiet until every booked result has come out.
    task automatic wait_pipeline_empty();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_vertices.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- sink
    // Random stall, or a long hold-off on request so the pipe backs up into o_in_stall.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- checker
    // Samples on the edge: every drive is nonblocking, so values seen are pre-edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (o_out_valid && !i_out_stall) begin
                if (pending_vertices.size() == 0) begin
                    $error("unexpected output transaction: x_out %0d y_out %0d saturated %0b",
                           o_x_out, o_y_out, o_saturated);
                    mismatches++;
                end else begin
                    head_v = pending_vertices.pop_front();
                    if (o_x_out !== head_v.x) begin
                        $error("x_out: expected %0d, got %0d", head_v.x, o_x_out);
                        mismatches++;
                    end
                    if (o_y_out !== head_v.y) begin
                        $error("y_out: expected %0d, got %0d", head_v.y, o_y_out);
                        mismatches++;
                    end
                    if (o_saturated !== head_v.sat) begin
                        $error("saturated: expected %0b, got %0b", head_v.sat, o_saturated);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction means the core hung.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no transaction for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        t_vec_row row;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. A row whose setup differs from the current one waits for
        // the pipe to empty and reloads all registers first.
        send_gap_pct = 10;
        stall_pct    = 62;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if ({row.mode, row.a, row.b, row.hx, row.hy, row.ang} !=
                    {cfg_mode, cfg_coef_a, cfg_coef_b, cfg_anchor_x, cfg_anchor_y, cfg_angle})
                begin
                wait_pipeline_empty();
                load_setup(row.mode, row.a, row.b, row.hx, row.hy, row.ang);
            end
            send_vertex(row.x, row.y, row.typed, '{row.ex, row.ey, row.es});
        end

        // Random part, three flow-control regimes: sparse source gaps with a busy
        // sink, the reverse, then full rate. Each block runs under a fresh setup.
        for (int regime = 0; regime < 3; regime++) begin
            send_gap_pct = (regime == 0) ? 10 : (regime == 1) ? 62 : 0;
            stall_pct    = (regime == 0) ? 62 : (regime == 1) ? 10 : 0;
            for (int blk = 0; blk < BLOCKS; blk++) begin
                wait_pipeline_empty();
                load_setup(($urandom_range(9) == 0) ? MODE_W'($urandom_range(7, 5))
                                                    : MODE_W'($urandom_range(4)),
                           pick_coef(), pick_coef(), pick_coord(), pick_coord(),
                           ANGLE_W'($urandom_range(511)));
                // writes to indexes past the map must leave the setup alone
                if (regime == 0 && blk == 0) begin
                    write_reg(REG_NONE_LO, CFG_W'($urandom));
                    write_reg(REG_NONE_HI, CFG_W'($urandom));
                end
                for (int n = 0; n < BLOCK_ITEMS; n++) begin
                    // full-rate regime: sink holds off long enough to back up the input
                    if (regime == 2 && blk == 2 && n == 1)
                        hold_asks <= hold_asks + 1;
                    // one pause mid-block until the pipe drains
                    if (regime == 1 && blk == 5 && n == 12)
                        wait_pipeline_empty();
                    send_vertex(pick_coord(), pick_coord(), 1'b0, '0);
                end
            end
        end

        // Drain, then watch a few more cycles for stray results.
        wait_pipeline_empty();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
